// File: hw/rtl/frns_pkg.sv
// Shared widths, codes and types for the fixed-radius neighbour search block.
`default_nettype none
package frns_pkg;

   localparam int KEY_W             = 48;
   localparam int POS_W             = 24;
   localparam int RAD_W             = 24;
   localparam int SLOT_W            = 5;
   localparam int STATUS_W          = 2;
   localparam int SLOT_SPAN         = 2 ** SLOT_W;
   localparam int TABLE_ENTRIES_DEF = 32;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_FOUND     = 2'd0,
      STAT_NONE      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_WRITTEN   = 2'd3
   } status_type;

   typedef struct packed {
      logic        [KEY_W-1:0] key;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [POS_W:0] abs_diff(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
      logic [POS_W:0] d;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      return d[POS_W] ? (~d + (POS_W+1)'(1)) : d;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fixed_radius_neighbour_search.sv
// Fixed-radius neighbour search over a table of node keys and 3-D positions.
//
// A write transaction (req_mode 0) is taken while idle and acknowledged by one
// result on the next cycle; busy stays low, so transactions may follow back to
// back. A query transaction (req_mode 1) holds busy high while a small sequencer
// walks the table through the one read port of the entry RAM: a pipelined key
// search and, if the node is found, a step to square the radius, a distance
// pass over the table, where one shared squarer handles dx, dy and dz in turn
// for each compared slot, then one closing step. A query's final result shows
// in the first cycle with busy low.
// Results appear on rsp_valid for exactly one cycle each and cannot be held
// off; the receiver must take every strobe. Neighbour results trail the scan by
// one hit so that the last one can carry rsp_last.
`default_nettype none
module fixed_radius_neighbour_search #(
   parameter int TABLE_ENTRIES = frns_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_mode,
   input  wire logic        [frns_pkg::SLOT_W-1:0]  req_slot,
   input  wire logic                                req_entry_valid,
   input  wire logic        [frns_pkg::KEY_W-1:0]   req_node_key,
   input  wire logic signed [frns_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic signed [frns_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic signed [frns_pkg::POS_W-1:0]   req_pos_z,
   input  wire logic        [frns_pkg::RAD_W-1:0]   req_radius,
   output logic                                     rsp_valid,
   output logic             [frns_pkg::STATUS_W-1:0] rsp_status,
   output logic             [frns_pkg::KEY_W-1:0]   rsp_neighbour_key,
   output logic signed      [frns_pkg::POS_W-1:0]   rsp_neighbour_x,
   output logic signed      [frns_pkg::POS_W-1:0]   rsp_neighbour_y,
   output logic signed      [frns_pkg::POS_W-1:0]   rsp_neighbour_z,
   output logic                                     rsp_last
);

   import frns_pkg::*;

   localparam int SPAN   = (TABLE_ENTRIES < SLOT_SPAN) ? TABLE_ENTRIES : SLOT_SPAN;
   localparam int AW     = $clog2(SPAN);
   localparam int IW     = AW + 1;
   localparam int SQ_W   = 2 * (POS_W + 1);
   localparam int PROD_W = 2 * POS_W + 1;
   localparam int D2_W   = PROD_W + 1;
   localparam int R2_W   = 2 * RAD_W;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_FIND = 10'b00_0000_0010,
      ST_RSQ  = 10'b00_0000_0100,
      ST_DRD  = 10'b00_0000_1000,
      ST_DX   = 10'b00_0001_0000,
      ST_DY   = 10'b00_0010_0000,
      ST_DZ   = 10'b00_0100_0000,
      ST_DSQ  = 10'b00_1000_0000,
      ST_DCMP = 10'b01_0000_0000,
      ST_FIN  = 10'b10_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic      [SPAN-1:0]    used_ff, used_in;
   logic      [IW-1:0]      idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic      [AW-1:0]      didx_ff, didx_in;
   logic      [KEY_W-1:0]   key_ff, key_in;
   logic      [POS_W-1:0]   self_x_ff, self_x_in;
   logic      [POS_W-1:0]   self_y_ff, self_y_in;
   logic      [POS_W-1:0]   self_z_ff, self_z_in;
   logic      [POS_W:0]     mag_ff, mag_in;
   logic      [PROD_W-1:0]  prod_ff, prod_in;
   logic      [D2_W-1:0]    acc_ff, acc_in;
   logic      [R2_W-1:0]    r2_ff, r2_in;
   logic                    hold_v_ff, hold_v_in;
   entry_type               hold_ff, hold_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   entry_type               rsp_entry_ff, rsp_entry_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    slot_ok;
   logic                    wr_en;
   logic      [AW-1:0]      wr_addr;
   entry_type               wr_entry;
   logic      [ENTRY_W-1:0] rd_word;
   entry_type               rd_entry;
   logic      [SQ_W-1:0]    sq;
   logic      [D2_W-1:0]    d2;
   logic                    issue;
   logic                    hit_key;
   logic                    last_d;

   frns_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SPAN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign slot_ok  = (int'(req_slot) < TABLE_ENTRIES);
   assign wr_addr  = req_slot[AW-1:0];
   assign wr_entry = '{key: req_node_key, x: req_pos_x, y: req_pos_y, z: req_pos_z};
   assign rd_entry = entry_type'(rd_word);
   assign sq       = mag_ff * mag_ff;
   assign d2       = acc_ff + D2_W'(prod_ff);
   assign issue    = (idx_ff < IW'(SPAN));
   assign hit_key  = (rd_entry.key == key_ff);
   assign last_d   = (idx_ff[AW-1:0] == AW'(SPAN - 1));

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      didx_in       = didx_ff;
      key_in        = key_ff;
      self_x_in     = self_x_ff;
      self_y_in     = self_y_ff;
      self_z_in     = self_z_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      r2_in         = r2_ff;
      hold_v_in     = hold_v_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_WRITE) begin
                  if (slot_ok) begin
                     used_in[wr_addr] = req_entry_valid;
                     wr_en            = req_entry_valid;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_WRITTEN;
                  rsp_entry_in  = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  key_in   = req_node_key;
                  mag_in   = {1'b0, req_radius};
                  idx_in   = '0;
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (issue) begin
               pend_in = 1'b1;
               didx_in = idx_ff[AW-1:0];
               idx_in  = idx_ff + IW'(1);
            end
            if (pend_ff) begin
               if (used_ff[didx_ff] && hit_key) begin
                  self_x_in = rd_entry.x;
                  self_y_in = rd_entry.y;
                  self_z_in = rd_entry.z;
                  pend_in   = 1'b0;
                  state_in  = ST_RSQ;
               end else if (didx_ff == AW'(SPAN - 1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NOT_FOUND;
                  rsp_entry_in  = '0;
                  rsp_last_in   = 1'b1;
                  pend_in       = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_RSQ: begin
            r2_in     = sq[R2_W-1:0];
            idx_in    = '0;
            hold_v_in = 1'b0;
            state_in  = ST_DRD;
         end
         ST_DRD: begin
            state_in = ST_DX;
         end
         ST_DX: begin
            if (!used_ff[idx_ff[AW-1:0]] || hit_key) begin
               if (last_d) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = ST_DRD;
               end
            end else begin
               mag_in   = abs_diff(rd_entry.x, self_x_ff);
               state_in = ST_DY;
            end
         end
         ST_DY: begin
            prod_in  = sq[PROD_W-1:0];
            mag_in   = abs_diff(rd_entry.y, self_y_ff);
            state_in = ST_DZ;
         end
         ST_DZ: begin
            acc_in   = D2_W'(prod_ff);
            prod_in  = sq[PROD_W-1:0];
            mag_in   = abs_diff(rd_entry.z, self_z_ff);
            state_in = ST_DSQ;
         end
         ST_DSQ: begin
            acc_in   = acc_ff + D2_W'(prod_ff);
            prod_in  = sq[PROD_W-1:0];
            state_in = ST_DCMP;
         end
         ST_DCMP: begin
            if (d2 < D2_W'(r2_ff)) begin
               hold_in   = rd_entry;
               hold_v_in = 1'b1;
               if (hold_v_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_FOUND;
                  rsp_entry_in  = hold_ff;
                  rsp_last_in   = 1'b0;
               end
            end
            if (last_d) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_DRD;
            end
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (hold_v_ff) begin
               rsp_status_in = STAT_FOUND;
               rsp_entry_in  = hold_ff;
            end else begin
               rsp_status_in = STAT_NONE;
               rsp_entry_in  = '0;
            end
            hold_v_in = 1'b0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      didx_ff       <= didx_in;
      key_ff        <= key_in;
      self_x_ff     <= self_x_in;
      self_y_ff     <= self_y_in;
      self_z_ff     <= self_z_in;
      mag_ff        <= mag_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      r2_ff         <= r2_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_neighbour_key = rsp_entry_ff.key;
   assign rsp_neighbour_x   = rsp_entry_ff.x;
   assign rsp_neighbour_y   = rsp_entry_ff.y;
   assign rsp_neighbour_z   = rsp_entry_ff.z;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/frns_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module frns_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: hw/rtl/frns_checker.sv
// Port-level checks for the fixed-radius neighbour search block, with its bind.
`default_nettype none
module frns_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                req_mode,
   input wire logic                                rsp_valid,
   input wire logic        [frns_pkg::STATUS_W-1:0] rsp_status,
   input wire logic        [frns_pkg::KEY_W-1:0]   rsp_neighbour_key,
   input wire logic signed [frns_pkg::POS_W-1:0]   rsp_neighbour_x,
   input wire logic signed [frns_pkg::POS_W-1:0]   rsp_neighbour_y,
   input wire logic signed [frns_pkg::POS_W-1:0]   rsp_neighbour_z,
   input wire logic                                rsp_last
);

   import frns_pkg::*;

   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_WRITE
      |=> rsp_valid && rsp_status == STAT_WRITTEN && rsp_last)
      else $error("write transaction not acknowledged on the next cycle");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_QUERY |=> busy)
      else $error("query transaction did not raise busy");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_FOUND
      |-> rsp_last && rsp_neighbour_key == '0 && rsp_neighbour_x == '0
          && rsp_neighbour_y == '0 && rsp_neighbour_z == '0)
      else $error("status result carries payload or lacks last");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy still high with the final result");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy && rsp_status == STAT_FOUND)
      else $error("non-final result outside a running query");

endmodule

bind fixed_radius_neighbour_search frns_checker u_frns_checker (.*);
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the fixed-radius neighbour search block.
module tb_top;
   import frns_pkg::*;

   localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
   localparam int ITEM_TARGET    = 420;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 300;
   localparam int FULL_SPREAD    = 8388607;

   localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic        [RAD_W-1:0] RAD_MAX  = '1;
   localparam logic        [KEY_W-1:0] KEY_ONES = '1;

   typedef struct {
      logic                    mode;
      logic [SLOT_W-1:0]       slot;
      logic                    entry_valid;
      logic [KEY_W-1:0]        key;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [RAD_W-1:0]        radius;
      bit                      drain;
   } frns_req_type;

   typedef struct {
      status_type              status;
      logic [KEY_W-1:0]        key;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic                    last_mark;
   } frns_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_mode = MODE_WRITE;
   logic [SLOT_W-1:0]       req_slot = '0;
   logic                    req_entry_valid = 1'b0;
   logic [KEY_W-1:0]        req_node_key = '0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic [RAD_W-1:0]        req_radius = '0;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [KEY_W-1:0]        rsp_neighbour_key;
   logic signed [POS_W-1:0] rsp_neighbour_x;
   logic signed [POS_W-1:0] rsp_neighbour_y;
   logic signed [POS_W-1:0] rsp_neighbour_z;
   logic                    rsp_last;

   fixed_radius_neighbour_search #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_slot          (req_slot),
      .req_entry_valid   (req_entry_valid),
      .req_node_key      (req_node_key),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_radius        (req_radius),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_neighbour_key (rsp_neighbour_key),
      .rsp_neighbour_x   (rsp_neighbour_x),
      .rsp_neighbour_y   (rsp_neighbour_y),
      .rsp_neighbour_z   (rsp_neighbour_z),
      .rsp_last          (rsp_last)
   );

   frns_req_type stimulus_q[$];
   frns_rsp_type expected_rsp_q[$];
   frns_req_type cur_req;
   bit        took = 1'b0;
   int        gap_left = 0;
   int        burst_left = 0;
   int        idle_cycles = 0;
   int        mismatches = 0;

   // table as the block should hold it
   bit                      tbl_used[TABLE_ENTRIES];
   logic [KEY_W-1:0]        tbl_key[TABLE_ENTRIES];
   logic signed [POS_W-1:0] tbl_x[TABLE_ENTRIES];
   logic signed [POS_W-1:0] tbl_y[TABLE_ENTRIES];
   logic signed [POS_W-1:0] tbl_z[TABLE_ENTRIES];

   // table as the generator sees it, used to aim queries at stored keys
   bit               gen_used[SLOT_SPAN];
   logic [KEY_W-1:0] gen_key[SLOT_SPAN];
   logic [KEY_W-1:0] key_pool[24];
   bit               drain_next = 1'b0;

   int writes_seen = 0, clears_seen = 0, queries_seen = 0;
   int missing_seen = 0, empty_seen = 0, hit_queries = 0, most_hits = 0;
   int results_checked = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void expect_status(input status_type st);
      frns_rsp_type rs;
      rs = '{st, '0, '0, '0, '0, 1'b1};
      expected_rsp_q.insert(expected_rsp_q.size(), rs);
   endfunction

   function automatic longint sq_span(input logic signed [POS_W-1:0] a,
                                      input logic signed [POS_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   function automatic void compute_neighbours(input frns_req_type rq);
      int        self_slot;
      int        hits;
      longint    r2;
      longint    d2;
      frns_rsp_type held;
      bit        have_held;
      self_slot = -1;
      hits      = 0;
      have_held = 1'b0;
      if (rq.mode == MODE_WRITE) begin
         writes_seen++;
         if (int'(rq.slot) < TABLE_ENTRIES) begin
            if (rq.entry_valid) begin
               tbl_used[rq.slot] = 1'b1;
               tbl_key[rq.slot]  = rq.key;
               tbl_x[rq.slot]    = rq.x;
               tbl_y[rq.slot]    = rq.y;
               tbl_z[rq.slot]    = rq.z;
            end else begin
               tbl_used[rq.slot] = 1'b0;
            end
         end
         if (!rq.entry_valid) clears_seen++;
         expect_status(STAT_WRITTEN);
         return;
      end
      queries_seen++;
      for (int i = 0; i < TABLE_ENTRIES && i < SLOT_SPAN; i++) begin
         if (self_slot < 0 && tbl_used[i] && tbl_key[i] == rq.key) self_slot = i;
      end
      if (self_slot < 0) begin
         missing_seen++;
         expect_status(STAT_NOT_FOUND);
         return;
      end
      r2 = longint'(rq.radius) * longint'(rq.radius);
      for (int i = 0; i < TABLE_ENTRIES && i < SLOT_SPAN; i++) begin
         if (tbl_used[i] && tbl_key[i] != rq.key) begin
            d2 = sq_span(tbl_x[i], tbl_x[self_slot]) + sq_span(tbl_y[i], tbl_y[self_slot])
               + sq_span(tbl_z[i], tbl_z[self_slot]);
            if (d2 < r2 && hits < SLOT_SPAN - 1) begin
               if (have_held) expected_rsp_q.insert(expected_rsp_q.size(), held);
               held      = '{STAT_FOUND, tbl_key[i], tbl_x[i], tbl_y[i], tbl_z[i], 1'b0};
               have_held = 1'b1;
               hits++;
            end
         end
      end
      if (have_held) begin
         held.last_mark = 1'b1;
         expected_rsp_q.insert(expected_rsp_q.size(), held);
         hit_queries++;
         if (hits > most_hits) most_hits = hits;
      end else begin
         empty_seen++;
         expect_status(STAT_NONE);
      end
   endfunction

   function automatic void check_field(input string fname, input logic [KEY_W-1:0] want_v,
                                       input logic [KEY_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
         mismatches++;
      end
   endfunction

   // driver: present the next transaction at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (stimulus_q.size() == 0 ||
                      (stimulus_q[0].drain && expected_rsp_q.size() != 0)) begin
            start <= 1'b0;
         end else begin
            cur_req = stimulus_q.pop_front();
            req_mode        <= cur_req.mode;
            req_slot        <= cur_req.slot;
            req_entry_valid <= cur_req.entry_valid;
            req_node_key    <= cur_req.key;
            req_pos_x       <= cur_req.x;
            req_pos_y       <= cur_req.y;
            req_pos_z       <= cur_req.z;
            req_radius      <= cur_req.radius;
            start           <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(16, 1);
               case ($urandom_range(9))
                  0, 1, 2, 3: gap_left = 0;
                  9:          gap_left = $urandom_range(30, 10);
                  default:    gap_left = $urandom_range(6, 1);
               endcase
            end else begin
               burst_left = burst_left - 1;
            end
         end
      end
   end

   // monitor: check results, then record the transaction taken at this edge
   always @(posedge clock) begin : monitor
      frns_rsp_type want;
      if (reset) begin
         took = 1'b0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected result, status %0d key %0h last %0b",
                        $time, rsp_status, rsp_neighbour_key, rsp_last);
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("status", KEY_W'(want.status), KEY_W'(rsp_status));
               check_field("neighbour_key", want.key, rsp_neighbour_key);
               check_field("neighbour_x", KEY_W'(want.x), KEY_W'(rsp_neighbour_x));
               check_field("neighbour_y", KEY_W'(want.y), KEY_W'(rsp_neighbour_y));
               check_field("neighbour_z", KEY_W'(want.z), KEY_W'(rsp_neighbour_z));
               check_field("last", KEY_W'(want.last_mark), KEY_W'(rsp_last));
               results_checked++;
            end
         end
         took = start && (busy === 1'b0);
         if (took) compute_neighbours(cur_req);
         if (took || rsp_valid === 1'b1) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d cycles without a transaction, %0d results due",
                     $time, idle_cycles, expected_rsp_q.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic logic [KEY_W-1:0] rand_key();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[KEY_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] rand_coord(input int center, input int spread);
      int          v;
      logic [31:0] r;
      if (spread >= FULL_SPREAD) begin
         r = $urandom();
         case ($urandom_range(9))
            0:       return POS_MIN;
            1:       return POS_MAX;
            default: return r[POS_W-1:0];
         endcase
      end
      v = center + int'($urandom_range(2 * spread)) - spread;
      return v[POS_W-1:0];
   endfunction

   function automatic void queue_item(input frns_req_type rq);
      rq.drain   = drain_next;
      drain_next = 1'b0;
      if (rq.mode == MODE_WRITE) begin
         gen_used[rq.slot] = rq.entry_valid;
         if (rq.entry_valid) gen_key[rq.slot] = rq.key;
      end
      stimulus_q.insert(stimulus_q.size(), rq);
   endfunction

   function automatic void add_write(input int slot, input bit valid, input logic [KEY_W-1:0] key,
                                     input logic signed [POS_W-1:0] x,
                                     input logic signed [POS_W-1:0] y,
                                     input logic signed [POS_W-1:0] z);
      frns_req_type rq;
      logic [31:0] r;
      r  = $urandom();
      rq = '{MODE_WRITE, slot[SLOT_W-1:0], valid, key, x, y, z, r[RAD_W-1:0], 1'b0};
      queue_item(rq);
   endfunction

   function automatic void add_query(input logic [KEY_W-1:0] key, input logic [RAD_W-1:0] radius);
      frns_req_type rq;
      logic [31:0] r;
      r  = $urandom();
      rq = '{MODE_QUERY, r[SLOT_W-1:0], r[5], key, rand_coord(0, FULL_SPREAD),
             rand_coord(0, FULL_SPREAD), rand_coord(0, FULL_SPREAD), radius, 1'b0};
      queue_item(rq);
   endfunction

   initial begin : stimulus
      logic [KEY_W-1:0] ka, kb, kc, k;
      int spread, center, lim, nw, nq, pick, s;
      int used_slots[$];
      logic [31:0] r;
      bit fill_done;

      ka = 48'h1234_5678_9ABC;
      kb = 48'hFEDC_BA98_7654;
      kc = 48'h8000_0000_0001;
      key_pool[0] = '0;
      key_pool[1] = KEY_ONES;
      for (int i = 2; i < 24; i++) key_pool[i] = rand_key();

      // directed: table edges, duplicates, clears and the strict radius bound
      add_query(ka, RAD_MAX);
      add_write(0, 1'b1, ka, '0, '0, '0);
      add_write(1, 1'b1, kb, POS_MAX, POS_MAX, POS_MAX);
      add_write(2, 1'b1, kc, POS_MIN, POS_MIN, POS_MIN);
      add_write(SLOT_SPAN - 1, 1'b1, KEY_ONES, 24'sd1, -24'sd1, '0);
      drain_next = 1'b1;
      add_query(ka, '0);
      add_query(ka, RAD_MAX);
      add_query(kb, RAD_MAX);
      add_write(3, 1'b1, ka, 24'sd5, 24'sd5, 24'sd5);
      add_query(ka, 24'd16);
      add_write(0, 1'b0, rand_key(), rand_coord(0, FULL_SPREAD), POS_MIN, POS_MAX);
      add_query(ka, 24'd16);
      add_write(4, 1'b1, '0, 24'sd8, 24'sd9, 24'sd5);
      add_query(ka, 24'd5);
      add_query(ka, 24'd6);
      add_query('0, RAD_MAX);
      add_write(5, 1'b0, KEY_ONES, POS_MAX, POS_MAX, POS_MAX);
      add_query(48'h5555_5555_5555, RAD_MAX);
      add_write(0, 1'b1, KEY_ONES, POS_MIN, POS_MAX, '0);
      add_query(KEY_ONES, RAD_MAX);
      add_query(kc, RAD_MAX);

      // random: clustered table loads followed by queries mostly aimed at stored keys
      fill_done = 1'b0;
      while (stimulus_q.size() < ITEM_TARGET) begin
         pick   = $urandom_range(9);
         spread = (pick < 5) ? 16 : (pick < 8) ? 4096 : FULL_SPREAD;
         lim    = FULL_SPREAD - spread;
         center = int'($urandom_range(2 * lim)) - lim;
         if (!fill_done || $urandom_range(7) == 0) begin
            for (int i = 0; i < SLOT_SPAN; i++) begin
               k = rand_key();
               k[SLOT_W-1:0] = i[SLOT_W-1:0];
               add_write(i, 1'b1, k, rand_coord(center, spread), rand_coord(center, spread),
                         rand_coord(center, spread));
            end
            fill_done = 1'b1;
         end else begin
            nw = $urandom_range(8);
            for (int i = 0; i < nw; i++) begin
               k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(23)] : rand_key();
               add_write($urandom_range(SLOT_SPAN - 1), $urandom_range(99) < 85, k,
                         rand_coord(center, spread), rand_coord(center, spread),
                         rand_coord(center, spread));
            end
         end
         if ($urandom_range(4) == 0) drain_next = 1'b1;
         nq = $urandom_range(6, 1);
         for (int i = 0; i < nq; i++) begin
            used_slots.delete();
            for (int j = 0; j < SLOT_SPAN; j++) begin
               if (gen_used[j]) used_slots.insert(used_slots.size(), j);
            end
            pick = $urandom_range(9);
            if (pick < 8 && used_slots.size() != 0) begin
               s = used_slots[$urandom_range(used_slots.size() - 1)];
               k = gen_key[s];
            end else begin
               k = (pick == 8) ? key_pool[$urandom_range(23)] : rand_key();
            end
            r = $urandom();
            case ($urandom_range(9))
               0:       add_query(k, '0);
               1:       add_query(k, RAD_MAX);
               2:       add_query(k, r[RAD_W-1:0]);
               default: begin
                  r = $urandom_range(3 * spread);
                  add_query(k, (r > RAD_MAX) ? RAD_MAX : r[RAD_W-1:0]);
               end
            endcase
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stimulus_q.size() != 0 || start || expected_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("Covered %0d writes (%0d clears) and %0d queries: %0d unknown node, %0d empty,",
               writes_seen, clears_seen, queries_seen, missing_seen, empty_seen);
      $display("%0d with neighbours (up to %0d in one query); %0d results checked.",
               hit_queries, most_hits, results_checked);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
